@@ sv/u8s_pkg.sv @@
`timescale 1ns / 1ps

package u8s_pkg;

  localparam logic [7:0] REPL_0     = 8'hEF;
  localparam logic [7:0] REPL_1     = 8'hBF;
  localparam logic [7:0] REPL_2     = 8'hBD;
  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] LEAD_MIN   = 8'hC2;
  localparam logic [7:0] LEAD_MAX   = 8'hF4;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] CONT_A0    = 8'hA0;
  localparam logic [7:0] CONT_90    = 8'h90;
  localparam logic [7:0] CONT_8F    = 8'h8F;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  localparam int TOK_MAX = 4;

  // one output token: a literal byte or a three-byte replacement
  typedef struct packed {
    logic       repl;
    logic [7:0] value;
  } tok_t;

  // all results of one request
  typedef struct packed {
    tok_t [TOK_MAX-1:0] tok;
    logic [2:0]         count;
    logic               eos;
  } desc_t;

  typedef struct packed {
    logic [2:0][7:0] held_bytes;
    logic [1:0]      held_count;
    logic [2:0]      expected_length;
  } held_t;

endpackage

@@ sv/u8s_step.sv @@
`timescale 1ns / 1ps

module u8s_step (
  input  logic [7:0]    in_byte,
  input  logic          eos,
  input  u8s_pkg::held_t cur,
  output u8s_pkg::held_t nxt,
  output u8s_pkg::desc_t desc
);

  logic       fresh_path;
  logic       cont;
  logic       second_ok;
  logic       ok;
  logic       complete;
  logic       extend;
  logic       broken;
  logic       is_ascii;
  logic       is_lead;
  logic [2:0] base;
  logic [2:0] n_main;
  logic [1:0] hc_mid;
  logic [7:0] lead;

  always_comb begin
    lead       = cur.held_bytes[0];
    fresh_path = (cur.held_count == 2'd0) ||
                 (cur.expected_length <= {1'b0, cur.held_count});
    cont       = (in_byte[7:6] == u8s_pkg::CONT_TAG);
    case (lead)
      u8s_pkg::LEAD_E0: second_ok = (in_byte >= u8s_pkg::CONT_A0);
      u8s_pkg::LEAD_ED: second_ok = (in_byte <  u8s_pkg::CONT_A0);
      u8s_pkg::LEAD_F0: second_ok = (in_byte >= u8s_pkg::CONT_90);
      u8s_pkg::LEAD_F4: second_ok = (in_byte <= u8s_pkg::CONT_8F);
      default:          second_ok = 1'b1;
    endcase
    ok       = cont && ((cur.held_count != 2'd1) || second_ok);
    complete = !fresh_path && ok &&
               (({1'b0, cur.held_count} + 3'd1) == cur.expected_length);
    extend   = !fresh_path && ok && !complete;
    broken   = !fresh_path && !ok;
    is_ascii = (in_byte < u8s_pkg::ASCII_TOP);
    is_lead  = (in_byte >= u8s_pkg::LEAD_MIN) && (in_byte <= u8s_pkg::LEAD_MAX);
    base     = broken ? {1'b0, cur.held_count} : 3'd0;

    // replacement is the default token
    for (int k = 0; k < u8s_pkg::TOK_MAX; k++) begin
      desc.tok[k].repl  = 1'b1;
      desc.tok[k].value = in_byte;
    end

    nxt    = cur;
    n_main = 3'd0;
    hc_mid = 2'd0;

    if (complete) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(cur.held_count)) begin
          desc.tok[k].repl  = 1'b0;
          desc.tok[k].value = cur.held_bytes[k];
        end
      end
      desc.tok[cur.held_count].repl = 1'b0;
      n_main = {1'b0, cur.held_count} + 3'd1;
      nxt.held_count      = 2'd0;
      nxt.expected_length = 3'd0;
    end else if (extend) begin
      nxt.held_bytes[(cur.held_count == 2'd1) ? 2'd1 : 2'd2] = in_byte;
      nxt.held_count = cur.held_count + 2'd1;
      hc_mid         = cur.held_count + 2'd1;
    end else begin
      if (is_lead) begin
        nxt.held_bytes[0]   = in_byte;
        nxt.held_count      = 2'd1;
        hc_mid              = 2'd1;
        if (in_byte < u8s_pkg::LEAD3_MIN) nxt.expected_length = 3'd2;
        else if (in_byte < u8s_pkg::LEAD4_MIN) nxt.expected_length = 3'd3;
        else nxt.expected_length = 3'd4;
        n_main = base;
      end else begin
        desc.tok[base[1:0]].repl = !is_ascii;
        nxt.held_count      = 2'd0;
        nxt.expected_length = 3'd0;
        n_main = base + 3'd1;
      end
    end

    // end of string: the tokens past n_main are already replacements
    if (eos && (hc_mid != 2'd0)) begin
      desc.count          = n_main + {1'b0, hc_mid};
      nxt.held_count      = 2'd0;
      nxt.expected_length = 3'd0;
    end else begin
      desc.count = n_main;
    end
    desc.eos = eos;
  end

endmodule

@@ sv/utf8_stream_sanitizer.sv @@
`timescale 1ns / 1ps

// UTF-8 sanitizer. Each request (one byte) goes into an input register and is
// decoded combinationally into a result register holding up to four tokens, each
// a literal byte or the three-byte replacement EF BF BD. The output side sends
// one byte per cycle while out_stall is low; a request that yields several
// bytes holds the next output-producing request in the input register until its
// last byte is taken (at most 12 bytes). Bytes that only open or extend a
// sequence give no output byte and pass even while the result register is busy.

module utf8_stream_sanitizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_end
);

  logic           in_q_valid;
  logic [7:0]     in_q_byte;
  logic           in_q_eos;
  u8s_pkg::held_t held;
  u8s_pkg::held_t held_next;
  u8s_pkg::desc_t step_desc;
  logic           desc_valid;
  u8s_pkg::desc_t desc;
  logic [1:0]     tok_idx;
  logic [1:0]     sub;
  u8s_pkg::tok_t  tok_cur;
  logic           cur_last_byte;
  logic           item_last;
  logic           out_take;
  logic           desc_free;
  logic           advance;
  logic           load;
  logic           in_take;

  u8s_step u_step (
    .in_byte (in_q_byte),
    .eos     (in_q_eos),
    .cur     (held),
    .nxt     (held_next),
    .desc    (step_desc)
  );

  always_comb begin
    tok_cur       = desc.tok[tok_idx];
    cur_last_byte = !tok_cur.repl || (sub == 2'd2);
    item_last     = cur_last_byte && ({1'b0, tok_idx} == (desc.count - 3'd1));
    out_take      = desc_valid && !out_stall;
    desc_free     = !desc_valid || (out_take && item_last);
    advance       = in_q_valid && ((step_desc.count == 3'd0) || desc_free);
    load          = advance && (step_desc.count != 3'd0);
    in_stall      = in_q_valid && !advance;
    in_take       = in_valid && !in_stall;

    out_valid = desc_valid;
    if (tok_cur.repl) begin
      case (sub)
        2'd0:    out_byte = u8s_pkg::REPL_0;
        2'd1:    out_byte = u8s_pkg::REPL_1;
        default: out_byte = u8s_pkg::REPL_2;
      endcase
    end else begin
      out_byte = tok_cur.value;
    end
    run_end    = item_last;
    string_end = item_last && desc.eos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid           <= 1'b0;
      desc_valid           <= 1'b0;
      held.held_count      <= 2'd0;
      held.expected_length <= 3'd0;
      tok_idx              <= 2'd0;
      sub                  <= 2'd0;
    end else begin
      if (in_take) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance) begin
        held.held_bytes      <= held_next.held_bytes;
        held.held_count      <= held_next.held_count;
        held.expected_length <= held_next.expected_length;
      end
      if (load) begin
        desc_valid <= 1'b1;
        tok_idx    <= 2'd0;
        sub        <= 2'd0;
      end else if (out_take && item_last) begin
        desc_valid <= 1'b0;
      end else if (out_take) begin
        if (cur_last_byte) begin
          tok_idx <= tok_idx + 2'd1;
          sub     <= 2'd0;
        end else begin
          sub <= sub + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_byte <= in_byte;
      in_q_eos  <= end_of_string;
    end
    if (load) begin
      desc <= step_desc;
    end
  end

  a_desc_nonempty: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> (desc.count != 3'd0))
    else $error("result register holds an empty request");

  a_tok_in_range: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> ({1'b0, tok_idx} < desc.count))
    else $error("token index past token count");

  a_sub_only_repl: assert property (@(posedge clk) disable iff (rst)
    (desc_valid && (sub != 2'd0)) |-> tok_cur.repl)
    else $error("byte offset on a literal token");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    (held.held_count != 2'd0) |-> (held.expected_length > {1'b0, held.held_count}))
    else $error("held count reached expected length");

  a_inq_hold: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && in_stall) |=> (in_q_valid && $stable(in_q_byte) && $stable(in_q_eos)))
    else $error("input register changed while stalled");

endmodule
